>>> hw/rtl/ens_pkg.sv
// Shared types, register map and constants for the encoder soft-acceleration block.
package ens_pkg;

  // Configuration register map
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_RESET_GAP = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FAST_GAP  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MID_GAP   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SLOW_GAP  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FAST_GAIN = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_MID_GAIN  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_SLOW_GAIN = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_MAX_STEP  = 3'd7;

  localparam int GAP_W  = 16;
  localparam int GAIN_W = 7;
  localparam int MAXS_W = 7;
  localparam int CFG_DATA_W = 16;

  typedef struct packed {
    logic [GAP_W-1:0]  reset_gap;
    logic [GAP_W-1:0]  fast_gap;
    logic [GAP_W-1:0]  mid_gap;
    logic [GAP_W-1:0]  slow_gap;
    logic [GAIN_W-1:0] fast_gain;
    logic [GAIN_W-1:0] mid_gain;
    logic [GAIN_W-1:0] slow_gain;
    logic [MAXS_W-1:0] max_step;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    reset_gap: 16'd400,
    fast_gap:  16'd40,
    mid_gap:   16'd100,
    slow_gap:  16'd180,
    fast_gain: 7'd20,
    mid_gain:  7'd16,
    slow_gain: 7'd13,
    max_step:  7'd6
  };

  // Gain of one, in tenths
  localparam logic [GAIN_W-1:0] GAIN_UNITY = 7'd10;

  // Accelerated deltas fit in 8 signed bits; their product with a gain in 16
  localparam int SDELTA_W = 8;
  localparam int PROD_W   = 16;
  localparam int MAG_W    = 15;

  // Divide by ten: floor(x / 10) = (x * 52429) >> 19 for x below 2**15
  localparam int QUOT_W = 11;
  localparam int RECIP_PROD_W = 32;
  localparam logic [RECIP_PROD_W-1:0] DIV10_RECIP = 32'd52429;
  localparam int DIV10_SHIFT = 19;
  localparam logic [MAG_W-1:0] TEN_MAG = 15'd10;

  // Product split as 10 * pq + pm, pm in 0..9
  localparam int PQ_W = 12;
  localparam int PM_W = 4;
  localparam logic [PM_W-1:0] TEN_PM = 4'd10;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    KIND_ZERO,
    KIND_PASS,
    KIND_ACCEL
  } kind_t;

  typedef struct packed {
    kind_t           kind;
    logic            clear;
    logic            neg;
    logic [PQ_W-1:0] pq;
    logic [PM_W-1:0] pm;
  } job_t;

endpackage

>>> hw/rtl/ens_cfg.sv
// Configuration register file with reset values.
module ens_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [ens_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [ens_pkg::CFG_DATA_W-1:0]     cfg_data,
  output ens_pkg::cfg_t                      cfg
);

  ens_pkg::cfg_t cfg_r;
  ens_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        ens_pkg::REG_RESET_GAP: cfg_nxt.reset_gap = cfg_data;
        ens_pkg::REG_FAST_GAP:  cfg_nxt.fast_gap  = cfg_data;
        ens_pkg::REG_MID_GAP:   cfg_nxt.mid_gap   = cfg_data;
        ens_pkg::REG_SLOW_GAP:  cfg_nxt.slow_gap  = cfg_data;
        ens_pkg::REG_FAST_GAIN: cfg_nxt.fast_gain = cfg_data[ens_pkg::GAIN_W-1:0];
        ens_pkg::REG_MID_GAIN:  cfg_nxt.mid_gain  = cfg_data[ens_pkg::GAIN_W-1:0];
        ens_pkg::REG_SLOW_GAIN: cfg_nxt.slow_gain = cfg_data[ens_pkg::GAIN_W-1:0];
        ens_pkg::REG_MAX_STEP:  cfg_nxt.max_step  = cfg_data[ens_pkg::MAXS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= ens_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> hw/rtl/ens_front.sv
// Front end: delta, classification, gain pick, product and divide-by-ten split.
module ens_front #(
  parameter int COUNT_BITS = 18,
  parameter int TIME_BITS  = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ens_pkg::cfg_t                cfg,
  input  logic                         push,
  output logic                         full,
  input  logic signed [COUNT_BITS-1:0] in_encoder_count,
  input  logic [31:0]                  in_now_ms,
  output logic                         q_push,
  input  logic                         q_full,
  output ens_pkg::job_t                q_job,
  output logic [COUNT_BITS:0]          q_delta
);

  localparam int STEP_W = COUNT_BITS + 1;

  logic [COUNT_BITS-1:0] last_count_r;
  logic [TIME_BITS-1:0]  last_event_r;

  // stage 1: classified beat
  logic                      s1_v_r;
  ens_pkg::kind_t            s1_kind_r;
  logic signed [STEP_W-1:0]  s1_delta_r;
  logic [ens_pkg::GAIN_W-1:0] s1_gain_r;
  logic                      s1_clear_r;

  // stage 2: product
  logic                       s2_v_r;
  ens_pkg::kind_t             s2_kind_r;
  logic [STEP_W-1:0]          s2_delta_r;
  logic signed [ens_pkg::PROD_W-1:0] s2_prod_r;
  logic                       s2_clear_r;

  logic accept, s2_free, s1_free;
  logic [TIME_BITS-1:0] now_t, elapsed;
  logic signed [STEP_W-1:0] delta, maxs_s;
  logic big;
  ens_pkg::kind_t kind;
  logic [ens_pkg::GAIN_W-1:0] gain;
  logic signed [ens_pkg::SDELTA_W-1:0] sd;
  logic signed [ens_pkg::GAIN_W:0] sg;
  logic signed [ens_pkg::PROD_W-1:0] prod;

  logic [ens_pkg::MAG_W-1:0] mag;
  logic [ens_pkg::RECIP_PROD_W-1:0] recip_prod;
  logic [ens_pkg::QUOT_W-1:0] quot;
  logic [ens_pkg::MAG_W-1:0] rem_full;
  logic [ens_pkg::PM_W-1:0] rem;

  assign s2_free = !s2_v_r || !q_full;
  assign s1_free = !s1_v_r || s2_free;
  assign full    = !s1_free;
  assign accept  = push && s1_free;

  assign now_t   = in_now_ms[TIME_BITS-1:0];
  assign elapsed = now_t - last_event_r;
  assign delta   = STEP_W'(in_encoder_count) - STEP_W'($signed(last_count_r));
  assign maxs_s  = $signed(STEP_W'(cfg.max_step));
  assign big     = (delta > maxs_s) || (delta < -maxs_s);

  always_comb begin
    if (delta == '0) begin
      kind = ens_pkg::KIND_ZERO;
    end else if (big) begin
      kind = ens_pkg::KIND_PASS;
    end else begin
      kind = ens_pkg::KIND_ACCEL;
    end
    // first gap that holds wins
    if (elapsed <= TIME_BITS'(cfg.fast_gap)) begin
      gain = cfg.fast_gain;
    end else if (elapsed <= TIME_BITS'(cfg.mid_gap)) begin
      gain = cfg.mid_gain;
    end else if (elapsed <= TIME_BITS'(cfg.slow_gap)) begin
      gain = cfg.slow_gain;
    end else begin
      gain = ens_pkg::GAIN_UNITY;
    end
  end

  // product of the narrow accelerated delta and the gain
  assign sd   = s1_delta_r[ens_pkg::SDELTA_W-1:0];
  assign sg   = $signed({1'b0, s1_gain_r});
  assign prod = ens_pkg::PROD_W'(sd) * ens_pkg::PROD_W'(sg);

  // split product into 10 * pq + pm with pm in 0..9
  assign mag = s2_prod_r[ens_pkg::PROD_W-1] ? ens_pkg::MAG_W'(-s2_prod_r)
                                            : s2_prod_r[ens_pkg::MAG_W-1:0];
  assign recip_prod = ens_pkg::RECIP_PROD_W'(mag) * ens_pkg::DIV10_RECIP;
  assign quot       = recip_prod[ens_pkg::DIV10_SHIFT +: ens_pkg::QUOT_W];
  assign rem_full   = mag - ens_pkg::MAG_W'(quot) * ens_pkg::TEN_MAG;
  assign rem        = rem_full[ens_pkg::PM_W-1:0];

  always_comb begin
    q_job.kind  = s2_kind_r;
    q_job.clear = s2_clear_r;
    q_job.neg   = s2_delta_r[STEP_W-1];
    if (!s2_prod_r[ens_pkg::PROD_W-1]) begin
      q_job.pq = ens_pkg::PQ_W'(quot);
      q_job.pm = rem;
    end else if (rem == '0) begin
      q_job.pq = -ens_pkg::PQ_W'(quot);
      q_job.pm = '0;
    end else begin
      q_job.pq = -ens_pkg::PQ_W'(quot) - ens_pkg::PQ_W'(1);
      q_job.pm = ens_pkg::TEN_PM - rem;
    end
  end

  assign q_delta = s2_delta_r;
  assign q_push  = s2_v_r && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_count_r <= '0;
      last_event_r <= '0;
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
    end else begin
      if (accept) begin
        // a zero delta leaves the count where it already is
        last_count_r <= in_encoder_count;
        if (kind == ens_pkg::KIND_ACCEL) begin
          last_event_r <= now_t;
        end
        s1_v_r <= 1'b1;
      end else if (s2_free) begin
        s1_v_r <= 1'b0;
      end
      if (s1_v_r && s2_free) begin
        s2_v_r <= 1'b1;
      end else if (!q_full) begin
        s2_v_r <= 1'b0;
      end
    end
    if (accept) begin
      s1_kind_r  <= kind;
      s1_delta_r <= delta;
      s1_gain_r  <= gain;
      s1_clear_r <= elapsed > TIME_BITS'(cfg.reset_gap);
    end
    if (s1_v_r && s2_free) begin
      s2_kind_r  <= s1_kind_r;
      s2_delta_r <= s1_delta_r;
      s2_prod_r  <= prod;
      s2_clear_r <= s1_clear_r;
    end
  end

endmodule

>>> hw/rtl/ens_queue.sv
// Short queue of classified beats between the front and back ends.
module ens_queue #(
  parameter int WIDTH = 38
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int DEPTH = ens_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic do_push, do_pop;

  assign full    = count_r == CNT_W'(DEPTH);
  assign empty   = count_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
    if (do_push) begin
      mem[wr_ptr_r] <= din;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");
`endif

endmodule

>>> hw/rtl/ens_back.sv
// Back end: remainder arithmetic, clamp, saturation and result register.
module ens_back #(
  parameter int COUNT_BITS     = 18,
  parameter int REMAINDER_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ens_pkg::cfg_t              cfg,
  input  logic                       q_empty,
  input  ens_pkg::job_t              q_job,
  input  logic [COUNT_BITS:0]        q_delta,
  output logic                       q_pop,
  output logic                       empty,
  input  logic                       pop,
  output logic signed [COUNT_BITS:0] out_step_out
);

  localparam int STEP_W = COUNT_BITS + 1;
  // remainder held as 10 * rq + rm with rm in 0..9
  localparam int QW  = REMAINDER_BITS - 2;
  localparam int QSW = ((QW > ens_pkg::PQ_W) ? QW : ens_pkg::PQ_W) + 2;
  localparam longint HI_VAL = (longint'(1) << (REMAINDER_BITS - 1)) - 1;
  localparam longint LO_MAG = longint'(1) << (REMAINDER_BITS - 1);
  localparam longint HQ_VAL = HI_VAL / 10;
  localparam longint LQ_VAL = -((LO_MAG + 9) / 10);
  localparam logic signed [QSW:0] HQ_S = (QSW+1)'(HQ_VAL);
  localparam logic signed [QSW:0] LQ_S = (QSW+1)'(LQ_VAL);
  localparam logic [ens_pkg::PM_W-1:0] HM = ens_pkg::PM_W'(HI_VAL - 10 * HQ_VAL);
  localparam logic [ens_pkg::PM_W-1:0] LM = ens_pkg::PM_W'(-LO_MAG - 10 * LQ_VAL);

  logic signed [QW-1:0]      rq_r, rq_nxt;
  logic [ens_pkg::PM_W-1:0]  rm_r, rm_nxt;
  logic                      out_v_r;
  logic signed [STEP_W-1:0]  step_r, step_nxt;

  logic signed [QW-1:0]      rq_in;
  logic [ens_pkg::PM_W-1:0]  rm_in;
  logic [ens_pkg::PM_W:0]    m_sum;
  logic                      wrap;
  logic [ens_pkg::PM_W-1:0]  mp;
  logic signed [QSW-1:0]     q_sum, a_trunc, a_forced, a_clamp, maxs_s;
  logic signed [QSW:0]       rq_diff;
  logic [ens_pkg::PQ_W-1:0]  pq;

  assign q_pop = !q_empty && (!out_v_r || pop);
  assign empty = !out_v_r;
  assign out_step_out = step_r;

  assign rq_in = q_job.clear ? '0 : rq_r;
  assign rm_in = q_job.clear ? '0 : rm_r;
  assign pq    = q_job.pq;

  assign m_sum = {1'b0, rm_in} + {1'b0, q_job.pm};
  assign wrap  = m_sum >= {1'b0, ens_pkg::TEN_PM};
  assign mp    = wrap ? ens_pkg::PM_W'(m_sum - {1'b0, ens_pkg::TEN_PM})
                      : m_sum[ens_pkg::PM_W-1:0];

  // sum = 10 * q_sum + mp, mp in 0..9
  assign q_sum = {{(QSW-QW){rq_in[QW-1]}}, rq_in}
               + {{(QSW-ens_pkg::PQ_W){pq[ens_pkg::PQ_W-1]}}, pq}
               + {{(QSW-1){1'b0}}, wrap};

  // truncate toward zero: a negative sum with a fraction rounds up
  assign a_trunc  = (q_sum < 0 && mp != '0) ? q_sum + QSW'(1) : q_sum;
  assign a_forced = (a_trunc == '0) ? (q_job.neg ? -QSW'(1) : QSW'(1)) : a_trunc;
  assign maxs_s   = $signed(QSW'(cfg.max_step));

  always_comb begin
    if (a_forced > maxs_s) begin
      a_clamp = maxs_s;
    end else if (a_forced < -maxs_s) begin
      a_clamp = -maxs_s;
    end else begin
      a_clamp = a_forced;
    end
  end

  // the new remainder is the sum minus ten times the step taken
  assign rq_diff = (QSW+1)'(q_sum) - (QSW+1)'(a_clamp);

  always_comb begin
    rq_nxt   = rq_r;
    rm_nxt   = rm_r;
    step_nxt = '0;
    case (q_job.kind)
      ens_pkg::KIND_PASS: begin
        rq_nxt   = '0;
        rm_nxt   = '0;
        step_nxt = $signed(q_delta);
      end
      ens_pkg::KIND_ACCEL: begin
        step_nxt = STEP_W'(a_clamp);
        if (rq_diff > HQ_S || (rq_diff == HQ_S && mp > HM)) begin
          rq_nxt = QW'(HQ_S);
          rm_nxt = HM;
        end else if (rq_diff < LQ_S || (rq_diff == LQ_S && mp < LM)) begin
          rq_nxt = QW'(LQ_S);
          rm_nxt = LM;
        end else begin
          rq_nxt = rq_diff[QW-1:0];
          rm_nxt = mp;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rq_r    <= '0;
      rm_r    <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (q_pop) begin
        rq_r    <= rq_nxt;
        rm_r    <= rm_nxt;
        out_v_r <= 1'b1;
      end else if (pop) begin
        out_v_r <= 1'b0;
      end
    end
    if (q_pop) begin
      step_r <= step_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_rm_digit: assert property (@(posedge clk) disable iff (!rst_n)
    rm_r < ens_pkg::TEN_PM)
    else $error("remainder digit out of range");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((QSW+1)'(rq_r) < HQ_S || ((QSW+1)'(rq_r) == HQ_S && rm_r <= HM))
    && ((QSW+1)'(rq_r) > LQ_S || ((QSW+1)'(rq_r) == LQ_S && rm_r >= LM)))
    else $error("remainder beyond saturation bounds");

  a_accel_step: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_job.kind == ens_pkg::KIND_ACCEL) |=>
      (step_r != '0)
      && (step_r <= $signed(STEP_W'($past(cfg.max_step))))
      && (step_r >= -$signed(STEP_W'($past(cfg.max_step)))))
    else $error("accelerated step zero or beyond max_step");
`endif

endmodule

>>> hw/rtl/encoder_soft_acceleration.sv
// Top level: encoder soft acceleration with decoupled front and back ends.
//
//   channel  | handshake        | payload
//   ---------+------------------+---------------------------------------
//   input    | push / full      | in_encoder_count, in_now_ms
//   result   | pop / empty      | out_step_out
//   config   | cfg_we           | cfg_index, cfg_data
//
// One beat is accepted per cycle while full is low; a result is visible after its
// input beat has passed the product stage, the queue write and the result register.
// The back end updates its remainder combinationally, registering it with each result.
// Reset (rst_n low, synchronous) loads register defaults and zeroes flags and history.
// A stalled result holds the back end; the queue then fills and full rises.
module encoder_soft_acceleration #(
  parameter int COUNT_BITS     = 18,
  parameter int TIME_BITS      = 32,
  parameter int REMAINDER_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  output logic                                full,
  input  logic signed [COUNT_BITS-1:0]        in_encoder_count,
  input  logic [31:0]                         in_now_ms,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [COUNT_BITS:0]          out_step_out,
  input  logic                                cfg_we,
  input  logic [ens_pkg::REG_IDX_W-1:0]       cfg_index,
  input  logic [ens_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int STEP_W = COUNT_BITS + 1;
  localparam int Q_W    = $bits(ens_pkg::job_t) + STEP_W;

  ens_pkg::cfg_t     cfg;
  ens_pkg::job_t     f_job, b_job;
  logic [STEP_W-1:0] f_delta, b_delta;
  logic              q_push, q_full, q_pop, q_empty;
  logic [Q_W-1:0]    q_din, q_dout;

  ens_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ens_front #(
    .COUNT_BITS (COUNT_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .push             (push),
    .full             (full),
    .in_encoder_count (in_encoder_count),
    .in_now_ms        (in_now_ms),
    .q_push           (q_push),
    .q_full           (q_full),
    .q_job            (f_job),
    .q_delta          (f_delta)
  );

  assign q_din = {f_job, f_delta};

  ens_queue #(
    .WIDTH (Q_W)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  assign b_job   = q_dout[Q_W-1:STEP_W];
  assign b_delta = q_dout[STEP_W-1:0];

  ens_back #(
    .COUNT_BITS     (COUNT_BITS),
    .REMAINDER_BITS (REMAINDER_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .q_empty      (q_empty),
    .q_job        (b_job),
    .q_delta      (b_delta),
    .q_pop        (q_pop),
    .empty        (empty),
    .pop          (pop),
    .out_step_out (out_step_out)
  );

endmodule
